### rtl/core/rchm_pkg.sv
// ----------------------------------------------------------------------------
// rchm_pkg
// Types and constants shared by the record count hash map blocks.
// ----------------------------------------------------------------------------
package rchm_pkg;

  localparam int KEY_W = 64;
  localparam int CNT_W = 7;

  localparam logic [1:0] OP_GET = 2'd0;
  localparam logic [1:0] OP_SET = 2'd1;
  localparam logic [1:0] OP_DEL = 2'd2;

  localparam int LOAD_NUM = 7;
  localparam int LOAD_DEN = 10;

  localparam int          MIX_SHIFT = 33;
  localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] rec_id;
    logic [CNT_W-1:0] set_count;
  } rchm_in_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] count_out;
    logic             status;
  } rchm_out_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } rchm_slot_t;

endpackage

### rtl/core/rchm_ram.sv
// ----------------------------------------------------------------------------
// rchm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rchm_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/rchm_hash.sv
// ----------------------------------------------------------------------------
// rchm_hash
// Home slot unit: fmix64 on one shared 32x32 multiplier. For a table size that
// is not a power of two the same multiplier folds the hash below 2^32 and takes
// the remainder by reciprocal multiplication; otherwise a plain mask.
// ----------------------------------------------------------------------------
module rchm_hash
  import rchm_pkg::*;
#(
  parameter int TABLE_SLOTS = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [KEY_W-1:0]               key,
  output logic                           done,
  output logic [$clog2(TABLE_SLOTS)-1:0] home
);

  localparam int            IDXW    = $clog2(TABLE_SLOTS);
  localparam bit            POW2    = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam logic [IDXW:0] MODN    = (IDXW + 1)'(TABLE_SLOTS);
  localparam logic [31:0]   FOLD_C  = 32'((64'd1 << 32) % 64'(TABLE_SLOTS));
  localparam logic [31:0]   RECIP_C = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));
  localparam logic [31:0]   SLOTS_C = 32'(TABLE_SLOTS);

  localparam logic [3:0] H_IDLE  = 4'd0;
  localparam logic [3:0] H_M0    = 4'd1;
  localparam logic [3:0] H_M1    = 4'd2;
  localparam logic [3:0] H_M2    = 4'd3;
  localparam logic [3:0] H_M3    = 4'd4;
  localparam logic [3:0] H_FOLD  = 4'd5;
  localparam logic [3:0] H_RECIP = 4'd6;
  localparam logic [3:0] H_BACK  = 4'd7;
  localparam logic [3:0] H_FIX   = 4'd8;

  logic [3:0]      st;
  logic            rnd;
  logic [63:0]     k;
  logic [63:0]     acc;
  logic [63:0]     prod;
  logic [IDXW:0]   rr;

  logic [31:0]     mul_a;
  logic [31:0]     mul_b;
  logic [63:0]     mul_p;
  logic [63:0]     cst;
  logic [31:0]     hi_sum;
  logic [63:0]     knew;
  logic [63:0]     kx;

  assign cst    = rnd ? MIX_C2 : MIX_C1;
  assign mul_p  = 64'(mul_a) * 64'(mul_b);
  assign hi_sum = acc[63:32] + prod[31:0];
  assign knew   = {hi_sum, acc[31:0]};
  assign kx     = knew ^ (knew >> MIX_SHIFT);

  always_comb begin
    case (st)
      H_M1: begin
        mul_a = k[63:32];
        mul_b = cst[31:0];
      end
      H_M2: begin
        mul_a = k[31:0];
        mul_b = cst[63:32];
      end
      H_FOLD: begin
        mul_a = k[63:32];
        mul_b = FOLD_C;
      end
      H_RECIP: begin
        mul_a = k[31:0];
        mul_b = RECIP_C;
      end
      H_BACK: begin
        mul_a = prod[63:32];
        mul_b = SLOTS_C;
      end
      default: begin
        mul_a = k[31:0];
        mul_b = cst[31:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= H_IDLE;
      done <= 1'b0;
    end else begin
      done <= ((st == H_M3) && rnd && POW2) || (st == H_FIX);
      case (st)
        H_IDLE: begin
          if (start) begin
            k   <= key ^ (key >> MIX_SHIFT);
            rnd <= 1'b0;
            st  <= H_M0;
          end
        end
        H_M0: begin
          prod <= mul_p;
          st   <= H_M1;
        end
        H_M1: begin
          acc  <= prod;
          prod <= mul_p;
          st   <= H_M2;
        end
        H_M2: begin
          acc[63:32] <= hi_sum;
          prod       <= mul_p;
          st         <= H_M3;
        end
        H_M3: begin
          k <= kx;
          if (!rnd) begin
            rnd <= 1'b1;
            st  <= H_M0;
          end else if (POW2) begin
            home <= kx[IDXW-1:0];
            st   <= H_IDLE;
          end else begin
            st <= H_FOLD;
          end
        end
        H_FOLD: begin
          // fold the upper word back in until the value fits 32 bits
          if (k[63:32] == '0) begin
            st <= H_RECIP;
          end else begin
            k <= mul_p + {32'd0, k[31:0]};
          end
        end
        H_RECIP: begin
          prod <= mul_p;
          st   <= H_BACK;
        end
        H_BACK: begin
          rr <= (IDXW + 1)'(k[31:0] - mul_p[31:0]);
          st <= H_FIX;
        end
        H_FIX: begin
          home <= (rr >= MODN) ? IDXW'(rr - MODN) : IDXW'(rr);
          st   <= H_IDLE;
        end
        default: begin
          st <= H_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/record_count_hash_map_unit.sv
// ----------------------------------------------------------------------------
// record_count_hash_map_unit
// Linear probing map from record id to count with backward-shift delete.
// ----------------------------------------------------------------------------
// flow: hash the key, then read and check slots from the home slot on until the probe ends;
//   sizes that are not a power of two add the fold and reciprocal steps to each hash
// throughput: one item at a time, set by the shared hash multiplier and the one RAM port;
//   busy drops with done except on delete: then it stays high through the chain shift
// reset: after rst the table is swept clear with busy high
// results are shown on result for one cycle with done; the receiver cannot stall
module record_count_hash_map_unit
  import rchm_pkg::*;
#(
  parameter int TABLE_SLOTS = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  rchm_in_t  cmd,
  output logic      done,
  output rchm_out_t result
);

  localparam int IDXW  = $clog2(TABLE_SLOTS);
  localparam int OCCW  = $clog2(TABLE_SLOTS + 1);
  localparam int LIMIT = (TABLE_SLOTS * LOAD_NUM) / LOAD_DEN;
  localparam logic [IDXW-1:0] LAST = IDXW'(TABLE_SLOTS - 1);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_HASH  = 4'd2;
  localparam logic [3:0] ST_PREQ  = 4'd3;
  localparam logic [3:0] ST_PCHK  = 4'd4;
  localparam logic [3:0] ST_DREQ  = 4'd5;
  localparam logic [3:0] ST_DCHK  = 4'd6;
  localparam logic [3:0] ST_DHASH = 4'd7;
  localparam logic [3:0] ST_DMOVE = 4'd8;
  localparam logic [3:0] ST_DCLR  = 4'd9;

  logic [3:0]      state;
  rchm_in_t        req;
  rchm_slot_t      ent;
  logic [IDXW-1:0] idx;
  logic [IDXW-1:0] hole;
  logic [IDXW-1:0] j;
  logic [IDXW-1:0] n;
  logic [OCCW-1:0] occ;

  logic            hash_start;
  logic [KEY_W-1:0] hash_key;
  logic            hash_done;
  logic [IDXW-1:0] hash_home;

  logic            we;
  logic [IDXW-1:0] waddr;
  rchm_slot_t      wdata;
  logic [IDXW-1:0] raddr;
  rchm_slot_t      rd_slot;

  logic            key_eq;
  logic            hit;
  logic            probe_end;
  logic            set_full;
  logic            stays;
  logic [IDXW-1:0] idx_inc;
  logic [IDXW-1:0] j_inc;

  assign busy = (state != ST_IDLE);

  assign idx_inc = (idx == LAST) ? '0 : idx + 1'b1;
  assign j_inc   = (j == LAST) ? '0 : j + 1'b1;

  assign key_eq    = (rd_slot.key == req.rec_id);
  assign hit       = rd_slot.valid && key_eq;
  assign probe_end = !rd_slot.valid || key_eq || (n == LAST);
  assign set_full  = (occ >= OCCW'(LIMIT)) || rd_slot.valid;

  always_comb begin
    if (hole <= j) begin
      stays = (hole < hash_home) && (hash_home <= j);
    end else begin
      stays = (hole < hash_home) || (hash_home <= j);
    end
  end

  assign hash_start = ((state == ST_IDLE) && start) ||
                      ((state == ST_DCHK) && rd_slot.valid);
  assign hash_key   = (state == ST_IDLE) ? cmd.rec_id : rd_slot.key;
  assign raddr      = (state == ST_DREQ) ? j : idx;

  rchm_hash #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_hash (
    .clk  (clk),
    .rst  (rst),
    .start(hash_start),
    .key  (hash_key),
    .done (hash_done),
    .home (hash_home)
  );

  rchm_ram #(
    .WIDTH($bits(rchm_slot_t)),
    .DEPTH(TABLE_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd_slot)
  );

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = '0;
    case (state)
      ST_CLEAR: begin
        we = 1'b1;
      end
      ST_PCHK: begin
        if (probe_end) begin
          if (req.op == OP_SET) begin
            if (hit || !set_full) begin
              we    = 1'b1;
              wdata = '{valid: 1'b1, key: req.rec_id, count: req.set_count};
            end
          end else if (req.op == OP_DEL && hit) begin
            we    = 1'b1;
            wdata = '{valid: 1'b0, key: rd_slot.key, count: rd_slot.count};
          end
        end
      end
      ST_DMOVE: begin
        we    = 1'b1;
        waddr = hole;
        wdata = ent;
      end
      ST_DCLR: begin
        we    = 1'b1;
        waddr = j;
        wdata = '{valid: 1'b0, key: ent.key, count: ent.count};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      idx   <= '0;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == ST_PCHK) && probe_end;
      case (state)
        ST_CLEAR: begin
          if (idx == LAST) begin
            state <= ST_IDLE;
          end else begin
            idx <= idx_inc;
          end
        end
        ST_IDLE: begin
          if (start) begin
            req   <= cmd;
            state <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            idx   <= hash_home;
            n     <= '0;
            state <= ST_PREQ;
          end
        end
        ST_PREQ: begin
          state <= ST_PCHK;
        end
        ST_PCHK: begin
          if (!probe_end) begin
            idx   <= idx_inc;
            n     <= n + 1'b1;
            state <= ST_PREQ;
          end else begin
            result.found     <= hit;
            result.count_out <= hit ? rd_slot.count : '0;
            result.status    <= (req.op == OP_SET) && !hit && set_full;
            if (req.op == OP_SET && !hit && !set_full) begin
              occ <= occ + 1'b1;
            end
            if (req.op == OP_DEL && hit) begin
              if (occ != '0) begin
                occ <= occ - 1'b1;
              end
              hole  <= idx;
              j     <= idx_inc;
              n     <= '0;
              state <= ST_DREQ;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_DREQ: begin
          state <= ST_DCHK;
        end
        ST_DCHK: begin
          ent <= rd_slot;
          if (rd_slot.valid) begin
            state <= ST_DHASH;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DHASH: begin
          if (hash_done) begin
            if (!stays) begin
              state <= ST_DMOVE;
            end else if (n == LAST) begin
              state <= ST_IDLE;
            end else begin
              j     <= j_inc;
              n     <= n + 1'b1;
              state <= ST_DREQ;
            end
          end
        end
        ST_DMOVE: begin
          state <= ST_DCLR;
        end
        ST_DCLR: begin
          hole <= j;
          if (n == LAST) begin
            state <= ST_IDLE;
          end else begin
            j     <= j_inc;
            n     <= n + 1'b1;
            state <= ST_DREQ;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_occ_limit: assert property (@(posedge clk) disable iff (rst)
    occ <= OCCW'(LIMIT))
    else $error("occupancy above load limit");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_PCHK)
    else $error("result strobe outside probe end");

  a_hash_wait: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> state == ST_HASH || state == ST_DHASH)
    else $error("hash finished while nobody waits");

  a_full_miss: assert property (@(posedge clk) disable iff (rst)
    done && result.status |-> !result.found && result.count_out == '0)
    else $error("full status on a found item");

endmodule

### tb/sv/map_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// map_reply_checker
// Watches the command and result channels of the record count hash map.
// Every accepted command is applied to a private copy of the slot table,
// which gives the reply it must produce. Replies come back in order and are
// checked field by field against the oldest reply still owed.
// ----------------------------------------------------------------------------
module map_reply_checker
  import rchm_pkg::*;
#(
  parameter int TABLE_SLOTS = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  rchm_in_t  cmd,
  input  logic      done,
  input  rchm_out_t result,
  output int        outstanding,
  output int        errors
);

  rchm_slot_t  slots [TABLE_SLOTS];
  int unsigned occupied;
  rchm_out_t   owed_replies [$];
  rchm_out_t   want;
  int          mismatches = 0;

  assign errors = mismatches;

  function automatic logic [63:0] mix64(logic [63:0] k);
    k ^= k >> MIX_SHIFT;
    k = k * MIX_C1;
    k ^= k >> MIX_SHIFT;
    k = k * MIX_C2;
    k ^= k >> MIX_SHIFT;
    return k;
  endfunction

  function automatic int unsigned home_slot(logic [63:0] k);
    return int'(mix64(k) % 64'(TABLE_SLOTS));
  endfunction

  function automatic int unsigned slot_after(int unsigned i);
    return (i + 1 >= TABLE_SLOTS) ? 0 : i + 1;
  endfunction

  // slot holding the key, or the empty slot that ends its chain
  function automatic int unsigned find_slot(logic [63:0] k);
    int unsigned i;
    i = home_slot(k);
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (!slots[i].valid || slots[i].key == k) return i;
      i = slot_after(i);
    end
    return i;
  endfunction

  // empty the hole and slide later chain members back into it
  function automatic void shift_back_from(int unsigned hole);
    int unsigned j;
    int unsigned h;
    logic        stays;
    j = slot_after(hole);
    slots[hole].valid = 1'b0;
    for (int n = 0; n < TABLE_SLOTS && slots[j].valid; n++) begin
      h = home_slot(slots[j].key);
      stays = (hole <= j) ? (hole < h && h <= j) : (hole < h || h <= j);
      if (!stays) begin
        slots[hole] = slots[j];
        slots[j].valid = 1'b0;
        hole = j;
      end
      j = slot_after(j);
    end
  endfunction

  function automatic rchm_out_t map_access(rchm_in_t c);
    int unsigned i;
    logic        hit;
    rchm_out_t   r;
    i = find_slot(c.rec_id);
    hit = slots[i].valid && slots[i].key == c.rec_id;
    r.found = hit;
    r.count_out = hit ? slots[i].count : '0;
    r.status = 1'b0;
    case (c.op)
      OP_SET: begin
        if (hit) begin
          slots[i].count = c.set_count;
        end else if ((occupied + 1) * LOAD_DEN > TABLE_SLOTS * LOAD_NUM
                     || slots[i].valid) begin
          r.status = 1'b1;
        end else begin
          slots[i].valid = 1'b1;
          slots[i].key = c.rec_id;
          slots[i].count = c.set_count;
          occupied++;
        end
      end
      OP_DEL: begin
        if (hit) begin
          shift_back_from(i);
          if (occupied > 0) occupied--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < TABLE_SLOTS; s++) slots[s] = '0;
      occupied = 0;
      owed_replies.delete();
    end else begin
      if (done) begin
        if (owed_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: reply with none owed: found=%0b count=%0d status=%0b",
                     $time, result.found, result.count_out, result.status);
        end else begin
          want = owed_replies.pop_front();
          if (result.found !== want.found || result.count_out !== want.count_out
              || result.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: reply mismatch: expected %0b/%0d/%0b, got %0b/%0d/%0b",
                       $time, want.found, want.count_out, want.status,
                       result.found, result.count_out, result.status);
          end
        end
      end
      if (start && !busy) owed_replies.push_back(map_access(cmd));
    end
    outstanding <= owed_replies.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives get, set and delete commands into the record count hash map: a
// short directed run over key and count extremes, then phases that fill the
// table past its load limit and drain it again over a reused key pool.
// Reply checking is done by map_reply_checker.
// ----------------------------------------------------------------------------
module testbench;
  import rchm_pkg::*;

  localparam int          SLOTS       = 256;
  localparam int          POOL_SIZE   = 256;
  localparam int          RAND_ITEMS  = 1830;
  localparam int          PHASE_LEN   = 350;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam logic [1:0]  OP_SPARE    = 2'd3;

  localparam logic [63:0] KEY_ZERO = 64'h0;
  localparam logic [63:0] KEY_ONES = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] KEY_MID  = 64'h0123_4567_89ab_cdef;
  localparam logic [63:0] KEY_ALT  = 64'haaaa_5555_aaaa_5555;

  logic      clk = 1'b0;
  logic      rst;
  logic      start;
  logic      busy;
  rchm_in_t  cmd;
  logic      done;
  rchm_out_t result;
  int        outstanding;
  int        errors;

  logic [63:0] key_pool [POOL_SIZE];
  logic        burst;
  int unsigned cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  record_count_hash_map_unit #(.TABLE_SLOTS(SLOTS)) u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  map_reply_checker #(.TABLE_SLOTS(SLOTS)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .result      (result),
    .outstanding (outstanding),
    .errors      (errors)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // entered at the edge where the previous item was taken
  task automatic issue(input logic [1:0] op, input logic [63:0] key,
                       input logic [6:0] cnt);
    int gap;
    gap = burst ? 0 : $urandom_range(6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= '{op: op, rec_id: key, set_count: cnt};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    int          roll;
    logic [1:0]  op;
    logic [63:0] key;
    logic [6:0]  cnt;
    logic        filling;

    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    burst = 1'b0;
    key_pool[0] = KEY_ZERO;
    key_pool[1] = KEY_ONES;
    key_pool[2] = 64'h1;
    key_pool[3] = 64'h8000_0000_0000_0000;
    for (int k = 4; k < POOL_SIZE; k++) key_pool[k] = {$urandom, $urandom};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: absent keys, extremes, update, spare op, delete
    issue(OP_GET, KEY_ZERO, 7'd0);
    issue(OP_DEL, KEY_ZERO, 7'd0);
    issue(OP_SET, KEY_ZERO, 7'd0);
    issue(OP_SET, KEY_ONES, 7'd127);
    issue(OP_GET, KEY_ZERO, 7'd127);
    issue(OP_GET, KEY_ONES, 7'd0);
    issue(OP_SET, KEY_ZERO, 7'd64);
    issue(OP_SPARE, KEY_ZERO, 7'd5);
    issue(OP_SET, KEY_MID, 7'd1);
    issue(OP_DEL, KEY_ONES, 7'd0);
    issue(OP_GET, KEY_ONES, 7'd0);
    issue(OP_SET, KEY_ONES, 7'h55);
    issue(OP_SET, KEY_ALT, 7'h2a);
    issue(OP_GET, KEY_ALT, 7'd0);
    issue(OP_SPARE, 64'h7777, 7'd0);
    issue(OP_DEL, 64'h7777, 7'd0);
    issue(OP_DEL, KEY_MID, 7'd0);
    issue(OP_GET, KEY_MID, 7'd0);
    issue(OP_DEL, KEY_ZERO, 7'd0);
    issue(OP_DEL, KEY_ONES, 7'd0);
    issue(OP_DEL, KEY_ALT, 7'd0);
    issue(OP_GET, KEY_ALT, 7'd0);

    // random: alternate fill and drain phases over the key pool
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 64 == 0) burst = ($urandom_range(3) == 0);
      filling = ((i / PHASE_LEN) % 2 == 0);
      roll = $urandom_range(99);
      if (filling)
        op = (roll < 85) ? OP_SET : (roll < 93) ? OP_GET : (roll < 98) ? OP_DEL : OP_SPARE;
      else
        op = (roll < 20) ? OP_SET : (roll < 40) ? OP_GET : (roll < 97) ? OP_DEL : OP_SPARE;
      if ($urandom_range(9) == 0) key = {$urandom, $urandom};
      else key = key_pool[$urandom_range(POOL_SIZE - 1)];
      cnt = ($urandom_range(4) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(64));
      issue(op, key, cnt);
    end
    start <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### record_count_hash_map_unit.f
rtl/core/rchm_pkg.sv
rtl/core/rchm_ram.sv
rtl/core/rchm_hash.sv
rtl/core/record_count_hash_map_unit.sv
tb/sv/map_reply_checker.sv
tb/sv/testbench.sv
